// ===== rtl/json_string_unescaper_macros.svh =====
// ----------------------------------------------------------------------------
// json_string_unescaper_macros
// Assertion macros used by the top file of the string unescaper.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_MACROS_SVH
`define JSON_STRING_UNESCAPER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define JSU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define JSU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and decode helpers of the string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_NUL = 2'd1,
    STAT_ESC = 2'd2,
    STAT_HEX = 2'd3
  } status_e;

  // scan modes, one-hot
  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_STR  = 7'b0000010,
    MODE_ESC  = 7'b0000100,
    MODE_HEX1 = 7'b0001000,
    MODE_HEX2 = 7'b0010000,
    MODE_HEX3 = 7'b0100000,
    MODE_HEX4 = 7'b1000000
  } mode_e;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    status_e    status;
  } result_t;

  // decoded character lookup
  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } lookup_t;

  // hex digit of either case, value in the low nibble
  function automatic lookup_t hex_digit(logic [7:0] c);
    lookup_t r;
    r.ok    = 1'b0;
    r.value = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r.ok    = 1'b1;
      r.value = c - CH_0;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      r.ok    = 1'b1;
      r.value = c - CH_UP_A + HEX_TEN;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      r.ok    = 1'b1;
      r.value = c - CH_LO_A + HEX_TEN;
    end
    return r;
  endfunction

  // single-character escape map, \u excluded
  function automatic lookup_t escape_char(logic [7:0] c);
    lookup_t r;
    r.ok    = 1'b1;
    r.value = c;
    case (c)
      CH_LO_N:   r.value = CH_LF;
      CH_LO_R:   r.value = CH_CR;
      CH_LO_T:   r.value = CH_TAB;
      CH_LO_F:   r.value = CH_FF;
      CH_LO_B:   r.value = CH_BS;
      CH_QUOTE:  r.value = CH_QUOTE;
      CH_SLASH:  r.value = CH_SLASH;
      CH_BSLASH: r.value = CH_BSLASH;
      default: begin
        r.ok    = 1'b0;
        r.value = 8'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/jsu_in_stage.sv =====
// ----------------------------------------------------------------------------
// jsu_in_stage
// Input register: holds one raw byte beat until the decoder takes it.
// ----------------------------------------------------------------------------
module jsu_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // room when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/jsu_core.sv =====
// ----------------------------------------------------------------------------
// jsu_core
// Scan state machine: decodes one byte per step and forms its result.
// ----------------------------------------------------------------------------
module jsu_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             emit_o,
  output jsu_pkg::result_t result_o
);

  jsu_pkg::mode_e   mode_q, mode_d;
  logic [3:0]       nib_q, nib_d;
  jsu_pkg::lookup_t hex;
  jsu_pkg::lookup_t esc;
  logic [7:0]       pair_byte;

  assign hex       = jsu_pkg::hex_digit(byte_i);
  assign esc       = jsu_pkg::escape_char(byte_i);
  assign pair_byte = {nib_q, hex.value[3:0]};

  // next state and result
  always_comb begin
    mode_d              = mode_q;
    nib_d               = nib_q;
    emit_o              = 1'b0;
    result_o.out_byte   = 8'd0;
    result_o.byte_valid = 1'b0;
    result_o.last       = 1'b0;
    result_o.status     = jsu_pkg::STAT_OK;
    unique case (mode_q) inside
      jsu_pkg::MODE_STR: begin
        if (byte_i == jsu_pkg::CH_QUOTE) begin
          mode_d        = jsu_pkg::MODE_IDLE;
          emit_o        = 1'b1;
          result_o.last = 1'b1;
        end else if (byte_i == jsu_pkg::CH_NUL) begin
          mode_d          = jsu_pkg::MODE_IDLE;
          nib_d           = 4'd0;
          emit_o          = 1'b1;
          result_o.last   = 1'b1;
          result_o.status = jsu_pkg::STAT_NUL;
        end else if (byte_i == jsu_pkg::CH_BSLASH) begin
          mode_d = jsu_pkg::MODE_ESC;
        end else begin
          emit_o              = 1'b1;
          result_o.out_byte   = byte_i;
          result_o.byte_valid = 1'b1;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (byte_i == jsu_pkg::CH_LO_U) begin
          mode_d = jsu_pkg::MODE_HEX1;
        end else if (esc.ok) begin
          mode_d              = jsu_pkg::MODE_STR;
          emit_o              = 1'b1;
          result_o.out_byte   = esc.value;
          result_o.byte_valid = 1'b1;
        end else begin
          mode_d          = jsu_pkg::MODE_IDLE;
          nib_d           = 4'd0;
          emit_o          = 1'b1;
          result_o.last   = 1'b1;
          result_o.status = jsu_pkg::STAT_ESC;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX2,
      jsu_pkg::MODE_HEX4: begin
        if (!hex.ok) begin
          mode_d          = jsu_pkg::MODE_IDLE;
          nib_d           = 4'd0;
          emit_o          = 1'b1;
          result_o.last   = 1'b1;
          result_o.status = jsu_pkg::STAT_HEX;
        end else if (mode_q == jsu_pkg::MODE_HEX1) begin
          nib_d  = hex.value[3:0];
          mode_d = jsu_pkg::MODE_HEX2;
        end else if (mode_q == jsu_pkg::MODE_HEX3) begin
          nib_d  = hex.value[3:0];
          mode_d = jsu_pkg::MODE_HEX4;
        end else if (mode_q == jsu_pkg::MODE_HEX2) begin
          // high byte of the pair is dropped when zero
          nib_d               = 4'd0;
          mode_d              = jsu_pkg::MODE_HEX3;
          emit_o              = (pair_byte != 8'd0);
          result_o.out_byte   = pair_byte;
          result_o.byte_valid = 1'b1;
        end else begin
          nib_d               = 4'd0;
          mode_d              = jsu_pkg::MODE_STR;
          emit_o              = 1'b1;
          result_o.out_byte   = pair_byte;
          result_o.byte_valid = 1'b1;
        end
      end
      default: begin
        // idle: wait for the opening quote
        mode_d = (byte_i == jsu_pkg::CH_QUOTE) ? jsu_pkg::MODE_STR : jsu_pkg::MODE_IDLE;
      end
    endcase
  end

  // state registers advance once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_IDLE;
      nib_q  <= 4'd0;
    end else if (step_i) begin
      mode_q <= mode_d;
      nib_q  <= nib_d;
    end
  end

endmodule

// ===== rtl/jsu_out_stage.sv =====
// ----------------------------------------------------------------------------
// jsu_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module jsu_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jsu_pkg::result_t result_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output jsu_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  jsu_pkg::result_t result_q;

  // free when empty or draining this cycle
  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/json_string_unescaper.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper
// Streaming unescaper for one quoted JSON string, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one raw byte per clock while the input register has room and gives
// at most one result per byte: a byte goes into the input register, is decoded
// by the scan state machine once the result register has room and lands in the
// result register. Sustained rate is one byte per cycle whenever the sink is
// ready; the input register and the result register set the latency. Bytes
// before an opening quote are dropped, a closing quote or an error gives a
// beat with tlast set and no content byte, \u pairs give their raw bytes with
// a zero high byte left out.

`include "json_string_unescaper_macros.svh"

module json_string_unescaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [2:0] m_axis_tuser    // [0] byte_valid, [2:1] status
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_room;
  logic             step;
  logic             emit;
  jsu_pkg::result_t core_result;
  jsu_pkg::result_t out_result;

  // decoder consumes a byte whenever the result register has room
  assign step = in_valid && out_room;

  jsu_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (step),
    .byte_o  (in_byte)
  );

  jsu_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte),
    .emit_o   (emit),
    .result_o (core_result)
  );

  jsu_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && emit),
    .result_i (core_result),
    .room_o   (out_room),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  // output beat packing
  assign m_axis_tdata = out_result.out_byte;
  assign m_axis_tlast = out_result.last;
  assign m_axis_tuser = {out_result.status, out_result.byte_valid};

  // checks
  `JSU_ASSERT_IMP(a_last_no_content, m_axis_tvalid && m_axis_tlast,
                  !m_axis_tuser[0] && m_axis_tdata == 8'd0, "end beat carries content")
  `JSU_ASSERT_IMP(a_content_ok, m_axis_tvalid && m_axis_tuser[0],
                  !m_axis_tlast && m_axis_tuser[2:1] == jsu_pkg::STAT_OK,
                  "content beat marked as end or error")
  `JSU_ASSERT_IMP(a_error_ends, m_axis_tvalid && m_axis_tuser[2:1] != jsu_pkg::STAT_OK,
                  m_axis_tlast, "error beat without tlast")
  `JSU_ASSERT_IMP(a_stall_cause, !s_axis_tready,
                  in_valid && m_axis_tvalid && !m_axis_tready,
                  "input stalled without a blocked result")

endmodule

// ===== tb/json_string_unescaper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_tb
// Self-checking bench for the streaming JSON string unescaper: raw bytes go in,
// a built-in model of the scan machine predicts every result beat, and each
// beat taken from the master side is checked field by field in order.
// ----------------------------------------------------------------------------

module json_string_unescaper_tb;
  import jsu_pkg::*;

  // scan position inside the text
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TEXT,
    SCAN_ESC,
    SCAN_HEX1,
    SCAN_HEX2,
    SCAN_HEX3,
    SCAN_HEX4
  } scan_e;

  // model of the unescaper plus the queue of beats still to come
  class unescape_scoreboard;
    scan_e      scan;
    logic [3:0] hi_nibble;
    result_t    expected_beats[$];
    int         errors;

    function new();
      scan      = SCAN_IDLE;
      hi_nibble = '0;
      errors    = 0;
    endfunction

    function int nibble_of(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c) - int'(CH_UP_A) + 10;
      if (c >= CH_LO_A && c <= CH_LO_F) return int'(c) - int'(CH_LO_A) + 10;
      return -1;
    endfunction

    function void push(logic [7:0] b, logic vld, logic lst, status_e st);
      result_t r;
      r.out_byte   = b;
      r.byte_valid = vld;
      r.last       = lst;
      r.status     = st;
      expected_beats.push_back(r);
    endfunction

    // error ends the string: back to idle, marker beat with no content
    function void abort(status_e st);
      scan      = SCAN_IDLE;
      hi_nibble = '0;
      push(8'h00, 1'b0, 1'b1, st);
    endfunction

    // one accepted input byte
    function void note_byte(logic [7:0] c);
      int         d;
      logic [7:0] b;
      logic       mapped;
      b      = '0;
      mapped = 1'b0;
      case (scan) inside
        SCAN_TEXT: begin
          if (c == CH_QUOTE) begin
            scan = SCAN_IDLE;
            push(8'h00, 1'b0, 1'b1, STAT_OK);
          end else if (c == CH_NUL) begin
            abort(STAT_NUL);
          end else if (c == CH_BSLASH) begin
            scan = SCAN_ESC;
          end else begin
            push(c, 1'b1, 1'b0, STAT_OK);
          end
        end
        SCAN_ESC: begin
          mapped = 1'b1;
          case (c) inside
            CH_LO_N: b = CH_LF;
            CH_LO_R: b = CH_CR;
            CH_LO_T: b = CH_TAB;
            CH_LO_F: b = CH_FF;
            CH_LO_B: b = CH_BS;
            CH_QUOTE, CH_SLASH, CH_BSLASH: b = c;
            CH_LO_U: begin
              mapped = 1'b0;
              scan   = SCAN_HEX1;
            end
            default: begin
              mapped = 1'b0;
              abort(STAT_ESC);
            end
          endcase
          if (mapped) begin
            scan = SCAN_TEXT;
            push(b, 1'b1, 1'b0, STAT_OK);
          end
        end
        SCAN_HEX1, SCAN_HEX3: begin
          d = nibble_of(c);
          if (d < 0) begin
            abort(STAT_HEX);
          end else begin
            hi_nibble = d[3:0];
            scan      = (scan == SCAN_HEX1) ? SCAN_HEX2 : SCAN_HEX4;
          end
        end
        SCAN_HEX2, SCAN_HEX4: begin
          d = nibble_of(c);
          if (d < 0) begin
            abort(STAT_HEX);
          end else begin
            b = {hi_nibble, d[3:0]};
            hi_nibble = '0;
            // a zero high byte of the pair is left out
            if (scan == SCAN_HEX2) begin
              scan = SCAN_HEX3;
              if (b != 8'h00) push(b, 1'b1, 1'b0, STAT_OK);
            end else begin
              scan = SCAN_TEXT;
              push(b, 1'b1, 1'b0, STAT_OK);
            end
          end
        end
        default: begin
          scan = (c == CH_QUOTE) ? SCAN_TEXT : SCAN_IDLE;
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // one beat taken from the master side
    task check_beat(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat with nothing expected: byte=%h valid=%b last=%b status=%0d",
                         got.out_byte, got.byte_valid, got.last, got.status));
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("byte_valid %b, expected %b", got.byte_valid, want.byte_valid));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_byte
  logic       m_axis_tlast;
  logic [2:0] m_axis_tuser;            // [0] byte_valid, [2:1] status

  unescape_scoreboard sb;
  result_t            seen_beat;
  int                 n_items     = 0;
  int                 sink_hold   = 0;
  bit                 src_idle_en = 1'b1;
  bit                 snk_idle_en = 1'b1;
  logic [7:0]         esc_chars[8] = '{CH_LO_N, CH_LO_R, CH_LO_T, CH_LO_F,
                                       CH_LO_B, CH_QUOTE, CH_SLASH, CH_BSLASH};

  json_string_unescaper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // sink side: random stalls while snk_idle_en is set
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else if (snk_idle_en && $urandom_range(0, 99) < 4) begin
      m_axis_tready <= 1'b0;
      sink_hold = $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_beat.out_byte   = m_axis_tdata;
      seen_beat.byte_valid = m_axis_tuser[0];
      seen_beat.last       = m_axis_tlast;
      seen_beat.status     = status_e'(m_axis_tuser[2:1]);
      sb.check_beat(seen_beat);
    end
  end

  // one input beat, with an optional random gap in front
  task automatic send_byte(logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 99) < 5) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    sb.note_byte(b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hex digit of random case, zero favored so that zero high bytes show up
  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) v = 0;
    if (v < 10) return 8'(int'(CH_0) + v);
    return 8'(int'($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + v - 10);
  endfunction

  // up to two stray bytes, then a well-formed string with random content, sometimes broken at the end
  task automatic send_random_string();
    int         n_seg;
    int         fault;
    int         kind;
    int         n_good;
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
      send_byte(c);
    end
    send_byte(CH_QUOTE);
    n_seg = $urandom_range(0, 12);
    fault = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
    repeat (n_seg) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        send_byte(c);
      end else if (kind < 8) begin
        send_byte(CH_BSLASH);
        send_byte(esc_chars[$urandom_range(0, 7)]);
      end else begin
        send_byte(CH_BSLASH);
        send_byte(CH_LO_U);
        repeat (4) send_byte(rand_hex_char());
      end
    end
    case (fault)
      1: send_byte(CH_NUL);
      2: begin
        send_byte(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) begin
          c = CH_NUL;
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (c inside {CH_LO_N, CH_LO_R, CH_LO_T, CH_LO_F, CH_LO_B,
                           CH_QUOTE, CH_SLASH, CH_BSLASH, CH_LO_U});
        end
        send_byte(c);
      end
      3: begin
        send_byte(CH_BSLASH);
        send_byte(CH_LO_U);
        n_good = $urandom_range(0, 3);
        repeat (n_good) send_byte(rand_hex_char());
        if ($urandom_range(0, 3) == 0) begin
          c = CH_NUL;
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (c inside {[CH_0:CH_9], [CH_UP_A:CH_UP_F], [CH_LO_A:CH_LO_F]});
        end
        send_byte(c);
      end
      default: send_byte(CH_QUOTE);
    endcase
  endtask

  // stimulus and end of run
  initial begin
    bit paused;
    int w;
    paused = 1'b0;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes outside a string are dropped, NUL and 0xff included
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("x\"");
    // content extremes and every single-character escape
    send_byte(8'h01);
    send_byte(8'hFF);
    send_text("\\n\\r\\t\\f\\b\\\"\\/\\\\");
    // unicode pairs: zero high byte left out, mixed case, all zero, then close
    send_text("\\u0041\\uABcd\\u0000\"");
    // NUL inside the string
    send_text("\"a");
    send_byte(CH_NUL);
    // bad escape, and NUL right after a backslash
    send_text("\"\\q\"\\");
    send_byte(CH_NUL);
    // bad hex digit after the high byte was given, and NUL as a hex digit
    send_text("\"\\u12G\"\\u");
    send_byte(CH_NUL);

    while (n_items < 1400) begin
      // hold the sender once until the pipeline has drained
      if (!paused && n_items >= 300) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.expected_beats.size() != 0);
      end
      src_idle_en = !(n_items >= 600 && n_items < 900);
      snk_idle_en = src_idle_en;
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_random_string();
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep watching for stray beats
    w = 0;
    while (sb.expected_beats.size() != 0 && w < 2000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.expected_beats.size() != 0)
      sb.report($sformatf("%0d expected beats never came", sb.expected_beats.size()));
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(400_000 * 10);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_in_stage.sv
rtl/jsu_core.sv
rtl/jsu_out_stage.sv
rtl/json_string_unescaper.sv
tb/json_string_unescaper_tb.sv
